// ===== hw/rtl/rrm_pkg.sv =====
// shared widths, constants, state types and a control struct for the running median
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rrm_pkg;

   localparam int SAMPLE_W = 12;
   localparam int LOAD_W   = 16;
   localparam int RES_W    = 28;
   localparam int HELD_W   = 4;

   localparam int WINDOW = 8;
   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);

   localparam logic [LOAD_W-1:0]   LOAD_RESET   = LOAD_W'(2560);
   localparam logic [SAMPLE_W-1:0] FULL_SCALE   = SAMPLE_W'(4095);
   localparam logic [SAMPLE_W-1:0] CLAMP_FACTOR = SAMPLE_W'(3299);
   localparam logic [SAMPLE_W-1:0] CLAMP_LIMIT  = SAMPLE_W'(2);

   localparam int MUL_STEPS = SAMPLE_W;
   localparam int DIV_STEPS = RES_W;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {
      R_IDLE,
      R_MUL,
      R_DIV
   } resist_state_type;

   typedef enum logic [1:0] {
      W_IDLE,
      W_SCAN,
      W_CHECK
   } window_state_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_RESIST,
      T_WINDOW,
      T_PUSH
   } top_state_type;

   typedef struct packed {
      logic             start;
      logic [RES_W-1:0] value;
   } window_wr_type;

endpackage

// ===== hw/rtl/rrm_resist.sv =====
// bit-serial resistance unit: shift-add multiply then restoring divide, one bit per cycle
// depends on rrm_pkg
`timescale 1ns / 1ps

module rrm_resist (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rrm_pkg::SAMPLE_W-1:0]  adc_sample,
   input  logic [rrm_pkg::LOAD_W-1:0]    load_resistance,
   output logic                          done,
   output logic [rrm_pkg::RES_W-1:0]     resistance
);
   import rrm_pkg::*;

   resist_state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] fct_ff, fct_in;
   logic [SAMPLE_W-1:0] dvs_ff, dvs_in;
   logic [LOAD_W-1:0]   mcand_ff, mcand_in;
   logic [RES_W-1:0]    acc_ff, acc_in;
   logic [SAMPLE_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic                done_ff, done_in;

   logic [SAMPLE_W:0]   rem_sh;
   logic                rem_ge;
   logic                clamp;

   assign clamp  = adc_sample < CLAMP_LIMIT;
   assign rem_sh = {rem_ff, acc_ff[RES_W-1]};
   assign rem_ge = rem_sh >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      fct_ff   <= fct_in;
      dvs_ff   <= dvs_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      fct_in   = fct_ff;
      dvs_in   = dvs_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         R_IDLE: begin
            if (start) begin
               // low readings hit the voltage clamp: fixed factor over a divisor of one
               fct_in   = clamp ? CLAMP_FACTOR : FULL_SCALE - adc_sample;
               dvs_in   = clamp ? SAMPLE_W'(1) : adc_sample;
               mcand_in = load_resistance;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = R_MUL;
            end
         end
         R_MUL: begin
            acc_in = {acc_ff[RES_W-2:0], 1'b0}
                     + (fct_ff[SAMPLE_W-1] ? RES_W'(mcand_ff) : RES_W'(0));
            fct_in = {fct_ff[SAMPLE_W-2:0], 1'b0};
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(MUL_STEPS - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = R_DIV;
            end
         end
         R_DIV: begin
            // quotient bits shift into the dividend register from the bottom
            rem_in = rem_ge ? SAMPLE_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[SAMPLE_W-1:0];
            acc_in = {acc_ff[RES_W-2:0], rem_ge};
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = R_IDLE;
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   assign done       = done_ff;
   assign resistance = acc_ff;

endmodule

// ===== hw/rtl/rrm_window.sv =====
// circular window store with fill count and rank-counting median search
// depends on rrm_pkg; one compare per cycle while scanning, through a two-read-port store
`timescale 1ns / 1ps

module rrm_window (
   input  logic                          clock,
   input  logic                          reset,
   input  rrm_pkg::window_wr_type        wr,
   output logic                          done,
   output logic [rrm_pkg::RES_W-1:0]     median_resistance,
   output logic [rrm_pkg::HELD_W-1:0]    samples_held
);
   import rrm_pkg::*;

   window_state_type state_ff, state_in;

   logic [RES_W-1:0] store_ff [WINDOW];
   logic             store_we;

   logic [IDX_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] lt_ff, lt_in;
   logic [CNT_W-1:0] le_ff, le_in;
   logic [RES_W-1:0] cand_q_ff;
   logic [RES_W-1:0] peer_q_ff;
   logic             peer_vld_ff, peer_vld_in;
   logic             peer_last_ff, peer_last_in;
   logic [RES_W-1:0] median_ff, median_in;
   logic             done_ff, done_in;

   logic [CNT_W-1:0] rank;
   logic             issue;

   assign rank  = fill_ff >> 1;
   assign issue = (state_ff == W_SCAN) && (j_ff != fill_ff);

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[wp_ff] <= wr.value;
      end
      cand_q_ff <= store_ff[i_ff[IDX_W-1:0]];
      peer_q_ff <= store_ff[j_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         peer_vld_ff  <= 1'b0;
         peer_last_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         peer_vld_ff  <= peer_vld_in;
         peer_last_ff <= peer_last_in;
         done_ff      <= done_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      lt_ff     <= lt_in;
      le_ff     <= le_in;
      median_ff <= median_in;
   end

   always_comb begin
      state_in     = state_ff;
      store_we     = 1'b0;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      lt_in        = lt_ff;
      le_in        = le_ff;
      median_in    = median_ff;
      done_in      = 1'b0;
      peer_vld_in  = issue;
      peer_last_in = issue && (j_ff == fill_ff - CNT_W'(1));
      case (state_ff)
         W_IDLE: begin
            if (wr.start) begin
               store_we = 1'b1;
               wp_in    = (wp_ff == IDX_W'(WINDOW - 1)) ? '0 : wp_ff + IDX_W'(1);
               if (fill_ff != CNT_W'(WINDOW)) begin
                  fill_in = fill_ff + CNT_W'(1);
               end
               i_in     = '0;
               j_in     = '0;
               lt_in    = '0;
               le_in    = '0;
               state_in = W_SCAN;
            end
         end
         W_SCAN: begin
            if (issue) begin
               j_in = j_ff + CNT_W'(1);
            end
            if (peer_vld_ff) begin
               lt_in = lt_ff + CNT_W'(peer_q_ff < cand_q_ff);
               le_in = le_ff + CNT_W'(peer_q_ff <= cand_q_ff);
            end
            if (peer_last_ff) begin
               state_in = W_CHECK;
            end
         end
         W_CHECK: begin
            // candidate is the median when the wanted rank falls in its run of equals
            if ((lt_ff <= rank) && (rank < le_ff)) begin
               median_in = cand_q_ff;
               done_in   = 1'b1;
               state_in  = W_IDLE;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               j_in     = '0;
               lt_in    = '0;
               le_in    = '0;
               state_in = W_SCAN;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   assign done              = done_ff;
   assign median_resistance = median_ff;
   assign samples_held      = HELD_W'(fill_ff);

endmodule

// ===== hw/rtl/resistance_running_median.sv =====
// top level: sensor resistance running median over an eight-entry window
// sequence: bit-serial multiply, divide and window write, then a scan over the n held samples
// per median candidate tried, then hand-over to the output register
// flow: one item at a time; the next request is taken once the result has reached the output
// register, which waits while the previous response is not yet taken
// reset: synchronous, active high; clears control, window fill and sets load resistance to 2560
`timescale 1ns / 1ps

module resistance_running_median (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rrm_pkg::SAMPLE_W-1:0]  req_adc_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rrm_pkg::RES_W-1:0]     rsp_median_resistance,
   output logic [rrm_pkg::HELD_W-1:0]    rsp_samples_held,
   input  logic                          csr_we,
   input  logic [rrm_pkg::LOAD_W-1:0]    csr_wdata
);
   import rrm_pkg::*;

   top_state_type state_ff, state_in;

   logic [LOAD_W-1:0] load_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]  rsp_med_ff, rsp_med_in;
   logic [HELD_W-1:0] rsp_held_ff, rsp_held_in;

   logic              res_start;
   logic              res_done;
   logic [RES_W-1:0]  res_value;
   window_wr_type     win_wr;
   logic              win_done;
   logic [RES_W-1:0]  win_median;
   logic [HELD_W-1:0] win_held;

   rrm_resist u_resist (
      .clock           (clock),
      .reset           (reset),
      .start           (res_start),
      .adc_sample      (req_adc_sample),
      .load_resistance (load_ff),
      .done            (res_done),
      .resistance      (res_value)
   );

   rrm_window u_window (
      .clock             (clock),
      .reset             (reset),
      .wr                (win_wr),
      .done              (win_done),
      .median_resistance (win_median),
      .samples_held      (win_held)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= LOAD_RESET;
      end else if (csr_we) begin
         load_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_med_ff  <= rsp_med_in;
      rsp_held_ff <= rsp_held_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_med_in   = rsp_med_ff;
      rsp_held_in  = rsp_held_ff;
      req_ready    = 1'b0;
      res_start    = 1'b0;
      win_wr.start = 1'b0;
      win_wr.value = res_value;
      case (state_ff)
         T_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_start = 1'b1;
               state_in  = T_RESIST;
            end
         end
         T_RESIST: begin
            if (res_done) begin
               win_wr.start = 1'b1;
               state_in     = T_WINDOW;
            end
         end
         T_WINDOW: begin
            if (win_done) begin
               state_in = T_PUSH;
            end
         end
         T_PUSH: begin
            // output register takes the result once the last transfer has gone
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_med_in   = win_median;
               rsp_held_in  = win_held;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_median_resistance = rsp_med_ff;
   assign rsp_samples_held      = rsp_held_ff;

endmodule
